### rtl/tsds_pkg.sv
package tsds_pkg;

    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 64;

    localparam int CFG_W  = 7;
    localparam int STEP_W = 5;
    localparam int IDX_W  = 2;
    localparam int ACC_W  = 22;
    localparam int RES_W  = 23;

    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CLS_BULK    = 2'd0;
    localparam logic [1:0] CLS_KEPT    = 2'd1;
    localparam logic [1:0] CLS_EXCL    = 2'd2;
    localparam logic [1:0] CLS_UNKNOWN = 2'd3;

    localparam logic [IDX_W-1:0] CFG_GRID_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GRID_Z = 2'd2;
    localparam logic [IDX_W-1:0] CFG_STEP   = 2'd3;

    // Minus one with 16 fraction bits, reported for kept non-bulk sites.
    localparam logic signed [RES_W-1:0] NONBULK_VAL = -23'sd65536;

    typedef struct packed {
        logic [1:0]         cls;
        logic signed [15:0] xx;
        logic signed [15:0] xy;
        logic signed [15:0] xz;
        logic signed [15:0] yy;
        logic signed [15:0] yz;
        logic signed [15:0] zz;
    } vox_t;

    // Column of three planes: [0] newest plane (z+1), [1] centre, [2] oldest.
    typedef vox_t [2:0] col_t;
    // Three rows of columns: [0] newest row (y+1), [1] centre, [2] oldest.
    typedef col_t [2:0] blk_t;
    // Three x positions: [0] newest (x+1), [1] centre, [2] oldest (x-1).
    typedef blk_t [2:0] win_t;
    // Plane store word: [0] one plane back, [1] two planes back.
    typedef vox_t [1:0] pair_t;
    // Row store word: [0] one row back, [1] two rows back.
    typedef col_t [1:0] rows_t;

    typedef struct packed {
        logic       emit;
        logic       fin;
        logic       xm;
        logic       xp;
        logic       ym;
        logic       yp;
        logic       zm;
        logic       zp;
        logic [5:0] cx;
        logic [5:0] cy;
        logic [5:0] cz;
    } meta_t;

endpackage

### rtl/tsds_ctrl.sv
module tsds_ctrl
    import tsds_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [IDX_W-1:0]                    cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                op,
    output logic                                shift,
    output meta_t                               meta,
    output logic [$clog2(MAX_X*MAX_Y)-1:0]      pa,
    output logic [$clog2(MAX_X)-1:0]            ax
);

    localparam int XA = $clog2(MAX_X);
    localparam int YA = $clog2(MAX_Y);
    localparam int ZA = $clog2(MAX_Z);
    localparam int PA = $clog2(MAX_X*MAX_Y);
    localparam int RST_GX = (MAX_X < 64) ? MAX_X : 64;
    localparam int RST_GY = (MAX_Y < 64) ? MAX_Y : 64;
    localparam int RST_GZ = (MAX_Z < 64) ? MAX_Z : 64;

    function automatic int clamp_size(int v, int hi);
        return (v < 3) ? 3 : ((v > hi) ? hi : v);
    endfunction

    logic [XA-1:0]     gxm1_reg, ax_reg, cx_reg;
    logic [YA-1:0]     gym1_reg, ay_reg, cy_reg;
    logic [ZA-1:0]     gzm1_reg, az_reg, cz_reg;
    logic [PA-1:0]     pa_reg;
    logic [STEP_W-1:0] step_reg;
    logic [3:0]        sx_reg, sy_reg, sz_reg;
    logic              started_reg, arr_done_reg, ctr_done_reg;

    logic acc, vox, at_lag, at_last_arr, at_last_ctr, proc, lattice;
    logic [XA+STEP_W-1:0] ex;
    logic [YA+STEP_W-1:0] ey;
    logic [ZA+STEP_W-1:0] ez;
    logic [3:0] sm1;
    logic [STEP_W-1:0] step_next;

    assign acc = in_valid && in_ready;
    assign vox = (op == OP_VOXEL);
    assign at_lag = (ax_reg == XA'(1)) && (ay_reg == YA'(1)) && (az_reg == ZA'(1));
    assign at_last_arr = (ax_reg == gxm1_reg) && (ay_reg == gym1_reg) && (az_reg == gzm1_reg);
    assign at_last_ctr = (cx_reg == gxm1_reg) && (cy_reg == gym1_reg) && (cz_reg == gzm1_reg);
    assign shift = acc && (vox ? !arr_done_reg : (arr_done_reg && !ctr_done_reg));
    assign proc = shift && (vox ? (started_reg || at_lag) : 1'b1);
    assign lattice = (sx_reg == 4'd0) && (sy_reg == 4'd0) && (sz_reg == 4'd0);
    assign sm1 = 4'(step_reg - 5'd1);

    assign ex = (XA+STEP_W)'(cx_reg) + (XA+STEP_W)'(step_reg);
    assign ey = (YA+STEP_W)'(cy_reg) + (YA+STEP_W)'(step_reg);
    assign ez = (ZA+STEP_W)'(cz_reg) + (ZA+STEP_W)'(step_reg);

    always_comb
    begin
        meta.emit = proc && lattice;
        meta.fin  = lattice && (ex > (XA+STEP_W)'(gxm1_reg))
                    && (ey > (YA+STEP_W)'(gym1_reg)) && (ez > (ZA+STEP_W)'(gzm1_reg));
        meta.xm   = (cx_reg != '0);
        meta.xp   = (cx_reg != gxm1_reg);
        meta.ym   = (cy_reg != '0);
        meta.yp   = (cy_reg != gym1_reg);
        meta.zm   = (cz_reg != '0);
        meta.zp   = (cz_reg != gzm1_reg);
        meta.cx   = 6'(cx_reg);
        meta.cy   = 6'(cy_reg);
        meta.cz   = 6'(cz_reg);
    end

    assign pa = pa_reg;
    assign ax = ax_reg;

    always_comb
    begin
        if (cfg_data[STEP_W-1:0] == '0)
        begin
            step_next = STEP_W'(1);
        end
        else if (cfg_data[STEP_W-1:0] > STEP_W'(16))
        begin
            step_next = STEP_W'(16);
        end
        else
        begin
            step_next = cfg_data[STEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gxm1_reg     <= XA'(RST_GX - 1);
            gym1_reg     <= YA'(RST_GY - 1);
            gzm1_reg     <= ZA'(RST_GZ - 1);
            step_reg     <= STEP_W'(2);
            ax_reg       <= '0;
            ay_reg       <= '0;
            az_reg       <= '0;
            pa_reg       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sz_reg       <= '0;
            started_reg  <= 1'b0;
            arr_done_reg <= 1'b0;
            ctr_done_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_X: gxm1_reg <= XA'(clamp_size(int'(cfg_data), MAX_X) - 1);
                CFG_GRID_Y: gym1_reg <= YA'(clamp_size(int'(cfg_data), MAX_Y) - 1);
                CFG_GRID_Z: gzm1_reg <= ZA'(clamp_size(int'(cfg_data), MAX_Z) - 1);
                CFG_STEP:   step_reg <= step_next;
                default:    step_reg <= step_reg;
            endcase
            ax_reg       <= '0;
            ay_reg       <= '0;
            az_reg       <= '0;
            pa_reg       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sz_reg       <= '0;
            started_reg  <= 1'b0;
            arr_done_reg <= 1'b0;
            ctr_done_reg <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                if (ax_reg == gxm1_reg)
                begin
                    ax_reg <= '0;
                    if (ay_reg == gym1_reg)
                    begin
                        ay_reg <= '0;
                        pa_reg <= '0;
                        az_reg <= (az_reg == gzm1_reg) ? '0 : az_reg + ZA'(1);
                    end
                    else
                    begin
                        ay_reg <= ay_reg + YA'(1);
                        pa_reg <= pa_reg + PA'(1);
                    end
                end
                else
                begin
                    ax_reg <= ax_reg + XA'(1);
                    pa_reg <= pa_reg + PA'(1);
                end
                if (vox && at_lag)
                begin
                    started_reg <= 1'b1;
                end
                if (vox && at_last_arr)
                begin
                    arr_done_reg <= 1'b1;
                end
            end
            if (proc)
            begin
                if (at_last_ctr)
                begin
                    ctr_done_reg <= 1'b1;
                end
                if (cx_reg == gxm1_reg)
                begin
                    cx_reg <= '0;
                    sx_reg <= '0;
                    if (cy_reg == gym1_reg)
                    begin
                        cy_reg <= '0;
                        sy_reg <= '0;
                        cz_reg <= (cz_reg == gzm1_reg) ? '0 : cz_reg + ZA'(1);
                        sz_reg <= (sz_reg == sm1) ? '0 : sz_reg + 4'd1;
                    end
                    else
                    begin
                        cy_reg <= cy_reg + YA'(1);
                        sy_reg <= (sy_reg == sm1) ? '0 : sy_reg + 4'd1;
                    end
                end
                else
                begin
                    cx_reg <= cx_reg + XA'(1);
                    sx_reg <= (sx_reg == sm1) ? '0 : sx_reg + 4'd1;
                end
            end
        end
    end

endmodule

### rtl/tsds_window.sv
module tsds_window
    import tsds_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_shift,
    input  meta_t                           in_meta,
    input  vox_t                            in_vox,
    input  logic [$clog2(MAX_X*MAX_Y)-1:0]  pa,
    input  logic [$clog2(MAX_X)-1:0]        ax,
    output logic                            win_valid,
    output meta_t                           win_meta,
    output win_t                            win
);

    localparam int XA = $clog2(MAX_X);
    localparam int PA = $clog2(MAX_X*MAX_Y);

    // Plane store holds the two previous planes of each in-plane position;
    // row store holds the two previous rows of three-plane columns.
    pair_t plane_mem [MAX_X*MAX_Y];
    rows_t row_mem [MAX_X];

    logic          s1_valid_reg, s2_valid_reg, win_valid_reg;
    meta_t         s1_meta_reg, s2_meta_reg, win_meta_reg;
    vox_t          s1_vox_reg;
    logic [PA-1:0] s1_pa_reg;
    logic [XA-1:0] s1_ax_reg, s2_ax_reg;
    pair_t         q1_reg;
    col_t          s2_col_reg;
    rows_t         q2_reg;
    win_t          win_reg;

    always_ff @(posedge clk)
    begin
        if (adv && in_shift)
        begin
            q1_reg <= plane_mem[pa];
        end
        if (adv && s1_valid_reg)
        begin
            plane_mem[s1_pa_reg] <= {q1_reg[0], s1_vox_reg};
            q2_reg <= row_mem[s1_ax_reg];
        end
        if (adv && s2_valid_reg)
        begin
            row_mem[s2_ax_reg] <= {q2_reg[0], s2_col_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg  <= in_meta;
            s1_vox_reg   <= in_vox;
            s1_pa_reg    <= pa;
            s1_ax_reg    <= ax;
            s2_meta_reg  <= s1_meta_reg;
            s2_col_reg   <= {q1_reg[1], q1_reg[0], s1_vox_reg};
            s2_ax_reg    <= s1_ax_reg;
            win_meta_reg <= s2_meta_reg;
            if (s2_valid_reg)
            begin
                win_reg <= {win_reg[1], win_reg[0], {q2_reg[1], q2_reg[0], s2_col_reg}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_shift;
            s2_valid_reg  <= s1_valid_reg;
            win_valid_reg <= s2_valid_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_meta  = win_meta_reg;
    assign win       = win_reg;

endmodule

### rtl/tsds_calc.sv
module tsds_calc
    import tsds_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    win_valid,
    input  meta_t                   win_meta,
    input  win_t                    win,
    output logic                    out_valid,
    output logic signed [RES_W-1:0] splay_bend,
    output logic                    is_bulk,
    output logic [5:0]              out_x,
    output logic [5:0]              out_y,
    output logic [5:0]              out_z,
    output logic                    is_final
);

    function automatic logic signed [ACC_W-1:0] tap(logic en, logic signed [15:0] v);
        return en ? ACC_W'(v) : '0;
    endfunction

    logic signed [ACC_W-1:0] ax_sum, mx_sum, a_ax_reg, a_mx_reg;
    logic signed [RES_W-1:0] v_sum;
    logic        a_valid_reg, a_emit_reg, a_bulk_reg, a_fin_reg;
    logic [5:0]  a_x_reg, a_y_reg, a_z_reg;
    logic        out_valid_reg, is_bulk_reg, is_final_reg;
    logic signed [RES_W-1:0] splay_bend_reg;
    logic [5:0]  out_x_reg, out_y_reg, out_z_reg;
    vox_t        c;
    meta_t       m;

    assign c = win[1][1][1];
    assign m = win_meta;

    always_comb
    begin
        ax_sum = tap(m.xp, win[0][1][1].xx) + tap(m.xm, win[2][1][1].xx)
               + tap(m.yp, win[1][0][1].yy) + tap(m.ym, win[1][2][1].yy)
               + tap(m.zp, win[1][1][0].zz) + tap(m.zm, win[1][1][2].zz)
               - (tap(1'b1, c.xx) <<< 1) - (tap(1'b1, c.yy) <<< 1)
               - (tap(1'b1, c.zz) <<< 1);
        mx_sum = tap(m.xp && m.yp, win[0][0][1].xy) + tap(m.xm && m.ym, win[2][2][1].xy)
               - tap(m.xp && m.ym, win[0][2][1].xy) - tap(m.xm && m.yp, win[2][0][1].xy)
               + tap(m.xp && m.zp, win[0][1][0].xz) + tap(m.xm && m.zm, win[2][1][2].xz)
               - tap(m.xp && m.zm, win[0][1][2].xz) - tap(m.xm && m.zp, win[2][1][0].xz)
               + tap(m.yp && m.zp, win[1][0][0].yz) + tap(m.ym && m.zm, win[1][2][2].yz)
               - tap(m.yp && m.zm, win[1][0][2].yz) - tap(m.ym && m.zp, win[1][2][0].yz);
    end

    // Axial terms count four times and each mixed sum twice.
    assign v_sum = (RES_W'(a_ax_reg) <<< 2) + (RES_W'(a_mx_reg) <<< 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ax_reg   <= ax_sum;
            a_mx_reg   <= mx_sum;
            a_emit_reg <= m.emit && (c.cls == CLS_BULK || c.cls == CLS_KEPT);
            a_bulk_reg <= (c.cls == CLS_BULK);
            a_fin_reg  <= m.fin;
            a_x_reg    <= m.cx;
            a_y_reg    <= m.cy;
            a_z_reg    <= m.cz;
            splay_bend_reg <= a_bulk_reg ? v_sum : NONBULK_VAL;
            is_bulk_reg    <= a_bulk_reg;
            is_final_reg   <= a_fin_reg;
            out_x_reg      <= a_x_reg;
            out_y_reg      <= a_y_reg;
            out_z_reg      <= a_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= win_valid;
            out_valid_reg <= a_valid_reg && a_emit_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign splay_bend = splay_bend_reg;
    assign is_bulk    = is_bulk_reg;
    assign is_final   = is_final_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;

endmodule

### rtl/tensor_second_derivative_stencil.sv
// Splay-bend stencil over a streamed symmetric tensor field. Voxels arrive in raster
// order (x fastest) with a site class; op marks flush ticks, which drain the trailing
// centres once the whole grid has been transferred. Each grid voxel and each
// draining flush tick advance a 3x3x3 window built from two line memories: a plane
// store indexed by the in-plane position that holds the two previous planes, and a
// row store indexed by x that holds the two previous rows of three-plane columns.
// Both are read and written back once per item, so the block takes one item per
// clock cycle; that rate is set by the single read and single write port of each
// store, and the output register stalls the whole pipeline only while a result
// waits to be taken. Results pass the plane-store, row-store, window, sum and output
// registers. Neighbours that fall outside the grid are masked to zero using the
// centre coordinates, so no clearing pass is needed after reset or after a
// configuration write, and any configuration write restarts the stream.
module tensor_second_derivative_stencil
    import tsds_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic signed [15:0]      q_xx,
    input  logic signed [15:0]      q_xy,
    input  logic signed [15:0]      q_xz,
    input  logic signed [15:0]      q_yy,
    input  logic signed [15:0]      q_yz,
    input  logic signed [15:0]      q_zz,
    input  logic [1:0]              site_class,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] splay_bend,
    output logic                    is_bulk,
    output logic [5:0]              out_x,
    output logic [5:0]              out_y,
    output logic [5:0]              out_z,
    output logic                    is_final
);

    logic  adv;
    logic  shift;
    meta_t meta;
    vox_t  in_vox;
    logic  win_valid;
    meta_t win_meta;
    win_t  win;
    logic [$clog2(MAX_X*MAX_Y)-1:0] pa;
    logic [$clog2(MAX_X)-1:0]       ax;

    // The pipeline moves whenever the output register is empty or being emptied.
    assign adv      = !(out_valid && !out_ready);
    assign in_ready = adv;

    // Excluded and unknown sites enter the window as a zero tensor, keeping their class
    // so that no result is produced for them.
    always_comb
    begin
        in_vox.cls = site_class;
        if (site_class == CLS_BULK || site_class == CLS_KEPT)
        begin
            in_vox.xx = q_xx;
            in_vox.xy = q_xy;
            in_vox.xz = q_xz;
            in_vox.yy = q_yy;
            in_vox.yz = q_yz;
            in_vox.zz = q_zz;
        end
        else
        begin
            in_vox.xx = '0;
            in_vox.xy = '0;
            in_vox.xz = '0;
            in_vox.yy = '0;
            in_vox.yz = '0;
            in_vox.zz = '0;
        end
    end

    tsds_ctrl #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .shift     (shift),
        .meta      (meta),
        .pa        (pa),
        .ax        (ax)
    );

    tsds_window #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_shift  (shift),
        .in_meta   (meta),
        .in_vox    (in_vox),
        .pa        (pa),
        .ax        (ax),
        .win_valid (win_valid),
        .win_meta  (win_meta),
        .win       (win)
    );

    tsds_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .win_valid  (win_valid),
        .win_meta   (win_meta),
        .win        (win),
        .out_valid  (out_valid),
        .splay_bend (splay_bend),
        .is_bulk    (is_bulk),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .is_final   (is_final)
    );

endmodule

### rtl/tsds_checker.sv
module tsds_checker
    import tsds_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [RES_W-1:0] splay_bend,
    input logic                    is_bulk,
    input logic                    is_final
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(splay_bend))
        else $error("stalled result changed");

    // Non-bulk sites always report minus one.
    a_nonbulk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_bulk |-> splay_bend == NONBULK_VAL)
        else $error("non-bulk result is not minus one");

    // Nothing can follow the final result in the next cycle.
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_final |=> !out_valid)
        else $error("result directly after the final one");

endmodule

bind tensor_second_derivative_stencil tsds_checker u_tsds_checker (.*);

### dv/tb_tensor_second_derivative_stencil.sv
`timescale 1ns / 100ps

// Self-checking bench for the splay-bend stencil. Voxel transfers and flush ticks
// are fed from a queue by a clocked driver. Each accepted transfer also runs
// through a local model of the stream, which pushes the expected result, if any,
// for the centre that the transfer completes. A clocked monitor compares every
// result transfer against the oldest expected result, field by field.
module tb_tensor_second_derivative_stencil;
    import tsds_pkg::*;

    localparam int GRID_CAP   = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z;
    localparam int STALL_HOLD = 2000;
    localparam int DRAIN_WAIT = 12;

    typedef struct packed {
        logic        o;
        logic [15:0] xx;
        logic [15:0] xy;
        logic [15:0] xz;
        logic [15:0] yy;
        logic [15:0] yz;
        logic [15:0] zz;
        logic [1:0]  c;
    } voxel_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] v;
        logic                    b;
        logic [5:0]              x;
        logic [5:0]              y;
        logic [5:0]              z;
        logic                    f;
    } splay_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = CFG_GRID_X;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = OP_VOXEL;
    logic signed [15:0] q_xx = '0;
    logic signed [15:0] q_xy = '0;
    logic signed [15:0] q_xz = '0;
    logic signed [15:0] q_yy = '0;
    logic signed [15:0] q_yz = '0;
    logic signed [15:0] q_zz = '0;
    logic [1:0] site_class = CLS_BULK;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [RES_W-1:0] splay_bend;
    logic is_bulk;
    logic [5:0] out_x;
    logic [5:0] out_y;
    logic [5:0] out_z;
    logic is_final;

    tensor_second_derivative_stencil uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .q_xx       (q_xx),
        .q_xy       (q_xy),
        .q_xz       (q_xz),
        .q_yy       (q_yy),
        .q_yz       (q_yz),
        .q_zz       (q_zz),
        .site_class (site_class),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .splay_bend (splay_bend),
        .is_bulk    (is_bulk),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .is_final   (is_final)
    );

    always #2 clk = ~clk;

    voxel_item_t   voxel_queue[$];
    splay_result_t splay_expected[$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  idle_en = 1'b0;

    // Model of the stream. The whole grid is kept, indexed by raster position;
    // the hardware only keeps a window, but every neighbour that a centre reads
    // has already been written in the current stream, so the two agree.
    shortint tensor_mem [0:5][0:GRID_CAP-1];
    logic [1:0] class_mem [0:GRID_CAP-1];
    int unsigned gx_raw = 64, gy_raw = 64, gz_raw = 64, step_raw = 2;
    int unsigned arrived = 0, centre = 0;
    int unsigned gx, gy, gz;

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int tensor_at(int x, int y, int z, int comp);
        if (x < 0 || y < 0 || z < 0 || x >= gx || y >= gy || z >= gz)
            return 0;
        return tensor_mem[comp][x + gx * (y + gy * z)];
    endfunction

    function automatic int axial_diff(int x, int y, int z, int dx, int dy, int dz, int comp);
        return tensor_at(x + dx, y + dy, z + dz, comp) + tensor_at(x - dx, y - dy, z - dz, comp)
             - 2 * tensor_at(x, y, z, comp);
    endfunction

    function automatic int mixed_diff(int x, int y, int z, int ax, int ay, int az,
                                      int bx, int by, int bz, int comp);
        return tensor_at(x + ax + bx, y + ay + by, z + az + bz, comp)
             + tensor_at(x - ax - bx, y - ay - by, z - az - bz, comp)
             - tensor_at(x + ax - bx, y + ay - by, z + az - bz, comp)
             - tensor_at(x - ax + bx, y - ay + by, z - az + bz, comp);
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_GRID_X: gx_raw = 32'(data);
            CFG_GRID_Y: gy_raw = 32'(data);
            CFG_GRID_Z: gz_raw = 32'(data);
            default:    step_raw = 32'(data[STEP_W-1:0]);
        endcase
        arrived = 0;
        centre  = 0;
    endfunction

    function automatic void evaluate_centre();
        int unsigned c, s, cx, cy, cz;
        int sum;
        splay_result_t r;
        c = centre;
        centre = c + 1;
        s  = clamp_u(step_raw, 1, 16);
        cx = c % gx;
        cy = (c / gx) % gy;
        cz = c / (gx * gy);
        if (cx % s != 0 || cy % s != 0 || cz % s != 0)
            return;
        if (class_mem[c] == CLS_EXCL || class_mem[c] == CLS_UNKNOWN)
            return;
        r.b = (class_mem[c] == CLS_BULK);
        if (r.b)
        begin
            sum = 4 * (axial_diff(cx, cy, cz, 1, 0, 0, 0) + axial_diff(cx, cy, cz, 0, 1, 0, 3)
                       + axial_diff(cx, cy, cz, 0, 0, 1, 5))
                + 2 * (mixed_diff(cx, cy, cz, 1, 0, 0, 0, 1, 0, 1)
                       + mixed_diff(cx, cy, cz, 1, 0, 0, 0, 0, 1, 2)
                       + mixed_diff(cx, cy, cz, 0, 1, 0, 0, 0, 1, 4));
            r.v = sum[RES_W-1:0];
        end
        else
        begin
            r.v = NONBULK_VAL;
        end
        r.x = cx[5:0];
        r.y = cy[5:0];
        r.z = cz[5:0];
        r.f = (cx == ((gx - 1) / s) * s) && (cy == ((gy - 1) / s) * s)
           && (cz == ((gz - 1) / s) * s);
        splay_expected.push_back(r);
    endfunction

    function automatic void predict_transfer(voxel_item_t it);
        int unsigned total, lag;
        bit kept;
        gx = clamp_u(gx_raw, 3, DEF_MAX_X);
        gy = clamp_u(gy_raw, 3, DEF_MAX_Y);
        gz = clamp_u(gz_raw, 3, DEF_MAX_Z);
        total = gx * gy * gz;
        lag   = gx * gy + gx + 1;
        kept  = (it.c == CLS_BULK) || (it.c == CLS_KEPT);
        if (it.o == OP_VOXEL)
        begin
            // Voxels beyond the end of the grid are dropped.
            if (arrived >= total)
                return;
            class_mem[arrived] = it.c;
            // Excluded and unknown classes store a zero tensor.
            tensor_mem[0][arrived] = kept ? it.xx : 16'h0000;
            tensor_mem[1][arrived] = kept ? it.xy : 16'h0000;
            tensor_mem[2][arrived] = kept ? it.xz : 16'h0000;
            tensor_mem[3][arrived] = kept ? it.yy : 16'h0000;
            tensor_mem[4][arrived] = kept ? it.yz : 16'h0000;
            tensor_mem[5][arrived] = kept ? it.zz : 16'h0000;
            arrived++;
            if (arrived - 1 >= lag && centre < total)
                evaluate_centre();
        end
        else if (arrived >= total && centre < total)
        begin
            // Flush ticks count only between grid completion and the last centre.
            evaluate_centre();
        end
    endfunction

    // Input driver. An item that is not accepted is held; otherwise the next one
    // is taken from the queue unless an idle burst is running.
    always @(posedge clk or negedge rst_n)
    begin : input_driver
        voxel_item_t nxt;
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_transfer({op, q_xx, q_xy, q_xz, q_yy, q_yz, q_zz, site_class});
            if (!(in_valid && !in_ready))
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (voxel_queue.size() > 0)
                begin
                    nxt = voxel_queue.pop_front();
                    op         <= nxt.o;
                    q_xx       <= nxt.xx;
                    q_xy       <= nxt.xy;
                    q_xz       <= nxt.xz;
                    q_yy       <= nxt.yy;
                    q_yz       <= nxt.yz;
                    q_zz       <= nxt.zz;
                    site_class <= nxt.c;
                    in_valid   <= 1'b1;
                    if (idle_en && $urandom_range(0, 11) == 0)
                        gap = $urandom_range(1, 19);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stall bursts on ready, a field-by-field comparison of
    // every result transfer, and a watchdog on cycles without any transfer.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        splay_result_t want;
        int stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 11) == 0)
                    stall = $urandom_range(1, 19);
            end

            if (out_valid && out_ready)
            begin
                if (splay_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: splay_bend=%0d at (%0d,%0d,%0d)",
                                 splay_bend, out_x, out_y, out_z);
                end
                else
                begin
                    want = splay_expected.pop_front();
                    if ({splay_bend, is_bulk, out_x, out_y, out_z, is_final} !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected v=%0d bulk=%0b xyz=(%0d,%0d,%0d)",
                                     want.v, want.b, want.x, want.y, want.z,
                                     " fin=%0b, got v=%0d bulk=%0b", want.f,
                                     splay_bend, is_bulk,
                                     " xyz=(%0d,%0d,%0d) fin=%0b",
                                     out_x, out_y, out_z, is_final);
                    end
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_HOLD)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_component(bit extremes);
        if (extremes || $urandom_range(0, 7) == 0)
            case ($urandom_range(0, 3))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        return 16'($urandom);
    endfunction

    function automatic voxel_item_t make_voxel(bit extremes);
        voxel_item_t it;
        int unsigned r;
        it.o  = OP_VOXEL;
        it.xx = pick_component(extremes);
        it.xy = pick_component(extremes);
        it.xz = pick_component(extremes);
        it.yy = pick_component(extremes);
        it.yz = pick_component(extremes);
        it.zz = pick_component(extremes);
        r = $urandom_range(0, 99);
        it.c = (r < 75) ? CLS_BULK : (r < 87) ? CLS_KEPT : (r < 97) ? CLS_EXCL : CLS_UNKNOWN;
        return it;
    endfunction

    function automatic voxel_item_t make_flush();
        voxel_item_t it;
        it = make_voxel(1'b0);
        it.o = OP_FLUSH;
        return it;
    endfunction

    // Registers are only written once every transfer is done and the pipeline
    // has had time to empty of items that produced no result.
    task automatic wait_idle();
        do @(posedge clk);
        while (voxel_queue.size() > 0 || in_valid || splay_expected.size() > 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_register(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One complete stream: configure, send the grid, then drain it with flush
    // ticks. Noise adds early flushes, voxels after completion and extra flushes.
    task automatic run_grid(int unsigned xs, int unsigned ys, int unsigned zs,
                            int unsigned st, bit extremes);
        int unsigned ex, ey, ez, total, lag;
        wait_idle();
        write_reg(CFG_STEP, CFG_W'(st));
        write_reg(CFG_GRID_Z, CFG_W'(zs));
        write_reg(CFG_GRID_Y, CFG_W'(ys));
        write_reg(CFG_GRID_X, CFG_W'(xs));
        ex = clamp_u(xs, 3, DEF_MAX_X);
        ey = clamp_u(ys, 3, DEF_MAX_Y);
        ez = clamp_u(zs, 3, DEF_MAX_Z);
        total = ex * ey * ez;
        lag   = ex * ey + ex + 1;
        voxel_queue.push_back(make_flush());
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                voxel_queue.push_back(make_flush());
            voxel_queue.push_back(make_voxel(extremes));
        end
        voxel_queue.push_back(make_voxel(extremes));
        for (int unsigned i = 0; i < lag; i++)
        begin
            voxel_queue.push_back(make_flush());
            if ($urandom_range(0, 49) == 0)
                voxel_queue.push_back(make_voxel(extremes));
        end
        repeat ($urandom_range(1, 3)) voxel_queue.push_back(make_flush());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest grid with every voxel at the value extremes, then
        // longer extents on x and y with the step at both ends.
        run_grid(3, 3, 3, 1, 1'b1);
        idle_en = 1'b1;
        run_grid(16, 3, 3, 1, 1'b0);
        run_grid(3, 16, 3, 16, 1'b0);

        // Out-of-range register values saturate; z reaches the largest extent.
        run_grid(0, 2, 127, 0, 1'b0);
        run_grid(6, 4, 3, 31, 1'b0);

        // Random small grids with random steps, idling switched per grid.
        repeat (3)
        begin
            idle_en = $urandom_range(0, 3) != 0;
            run_grid($urandom_range(1, 8), $urandom_range(1, 7), $urandom_range(1, 6),
                     $urandom_range(0, 31) < 24 ? $urandom_range(1, 3) : $urandom_range(0, 31),
                     $urandom_range(0, 9) == 0);
        end

        // The closing stretch runs without any idling.
        idle_en = 1'b0;
        run_grid($urandom_range(3, 6), $urandom_range(3, 6), $urandom_range(3, 6), 1, 1'b0);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && splay_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
